FILE: hw/rtl/cba_pkg.sv
// Shared types and codes of the contiguous block allocator.
package cba_pkg;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [6:0] ACTIVE_RESET = 7'd64;

   typedef struct packed {
      logic       command;
      logic [6:0] run_length;
      logic [5:0] first_block;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_start;
   } rsp_type;

   typedef struct packed {
      logic [6:0] active_blocks;
   } csr_type;

   // bitmap write strobe and data
   typedef struct packed {
      logic en;
      logic value;
   } map_wr_type;

endpackage

FILE: hw/rtl/cba_chan_if.sv
// Valid/ready channel carrying one payload item.
interface cba_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cba_bitmap.sv
// Free bitmap memory: one write port, one registered read port.
module cba_bitmap #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                          clock,
   input  cba_pkg::map_wr_type           wr,
   input  logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
   input  logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
   output logic                          rd_bit
);
   logic mem_ff [NUM_BLOCKS];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.value;
      end
      rd_bit_ff <= mem_ff[rd_addr];
   end

   assign rd_bit = rd_bit_ff;
endmodule

FILE: hw/rtl/cba_ctrl.sv
// Sequencer: clear pass, first-fit scan, run marking and result register.
module cba_ctrl #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cba_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cba_pkg::rsp_type              rsp_data,
   input  logic [6:0]                    active_blocks,
   output cba_pkg::map_wr_type           map_wr,
   output logic [$clog2(NUM_BLOCKS)-1:0] map_wr_addr,
   output logic [$clog2(NUM_BLOCKS)-1:0] map_rd_addr,
   input  logic                          map_rd_bit
);
   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int N_W   = (CNT_W > 7) ? CNT_W : 7;
   localparam int SUM_W = N_W + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_SCAN  = 5'b00100,
      S_MARK  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [6:0]       len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [N_W-1:0]   iss_ff, iss_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             mark_val_ff, mark_val_in;
   logic [1:0]       status_ff, status_in;
   logic [5:0]       granted_ff, granted_in;

   logic [N_W-1:0]   n_blk;
   logic [SUM_W-1:0] free_end;
   logic             req_bad;
   logic             iss_live;
   logic [6:0]       cnt_inc;
   logic [IDX_W-1:0] run_start;

   // active count, clamped to the built size
   assign n_blk = (N_W'(active_blocks) > N_W'(NUM_BLOCKS)) ? N_W'(NUM_BLOCKS)
                                                           : N_W'(active_blocks);
   assign free_end = SUM_W'(req_data.first_block) + SUM_W'(req_data.run_length);
   assign req_bad  = (req_data.run_length == 7'd0) ||
                     ((req_data.command == cba_pkg::CMD_ALLOC) &&
                      (N_W'(req_data.run_length) > n_blk)) ||
                     ((req_data.command == cba_pkg::CMD_FREE) &&
                      (free_end > SUM_W'(n_blk)));
   assign iss_live  = iss_ff < n_blk;
   assign cnt_inc   = cnt_ff + 7'd1;
   assign run_start = (cnt_ff == 7'd0) ? chk_idx_ff : start_ff;

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      iss_in      = iss_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      cnt_in      = cnt_ff;
      start_in    = start_ff;
      mark_val_in = mark_val_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      map_wr.en   = 1'b0;
      map_wr.value = mark_val_ff;
      map_wr_addr = idx_ff;
      map_rd_addr = iss_ff[IDX_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            map_wr.en    = 1'b1;
            map_wr.value = 1'b1;
            idx_in       = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               len_in     = req_data.run_length;
               granted_in = '0;
               priority if (req_bad) begin
                  status_in = cba_pkg::STATUS_INVALID;
                  state_in  = S_RESP;
               end else if (req_data.command == cba_pkg::CMD_ALLOC) begin
                  iss_in     = '0;
                  cnt_in     = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end else begin
                  idx_in      = IDX_W'(req_data.first_block);
                  mark_val_in = 1'b1;
                  status_in   = cba_pkg::STATUS_DONE;
                  state_in    = S_MARK;
               end
            end
         end
         S_SCAN: begin
            // read of block iss_ff lands next cycle as the bit of chk_idx_ff
            chk_vld_in = iss_live;
            chk_idx_in = iss_ff[IDX_W-1:0];
            if (iss_live) begin
               iss_in = iss_ff + N_W'(1);
            end
            if (chk_vld_ff) begin
               if (map_rd_bit) begin
                  start_in = run_start;
                  cnt_in   = cnt_inc;
                  if (cnt_inc == len_ff) begin
                     idx_in      = run_start;
                     mark_val_in = 1'b0;
                     status_in   = cba_pkg::STATUS_DONE;
                     granted_in  = 6'(run_start);
                     chk_vld_in  = 1'b0;
                     state_in    = S_MARK;
                  end
               end else begin
                  cnt_in = '0;
               end
            end else if (!iss_live) begin
               status_in  = cba_pkg::STATUS_NOSPACE;
               granted_in = '0;
               state_in   = S_RESP;
            end
         end
         S_MARK: begin
            map_wr.en = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
            len_in    = len_ff - 7'd1;
            if (len_ff == 7'd1) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      iss_ff      <= iss_in;
      chk_vld_ff  <= chk_vld_in;
      chk_idx_ff  <= chk_idx_in;
      cnt_ff      <= cnt_in;
      start_ff    <= start_in;
      mark_val_ff <= mark_val_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
   end

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = (state_ff == S_RESP);
   assign rsp_data.status        = status_ff;
   assign rsp_data.granted_start = granted_ff;
endmodule

FILE: hw/rtl/contiguous_block_allocator.sv
// First-fit contiguous block allocator over a free bitmap of disk blocks.
// Channels: req_chan takes one command item (allocate a run of run_length
// blocks, or free run_length blocks from first_block); rsp_chan returns one
// item per command with status and granted_start; csr_chan writes
// active_blocks, the number of usable blocks (clamped to NUM_BLOCKS).
// Write csr_chan only while no command is in flight; it is always ready.
// Timing: one item at a time. An invalid command answers in the cycle after
// acceptance, a free marks its run_length blocks free one after another, and
// an allocate scans one block per cycle through the bitmap read port and
// then marks the granted run. req_chan is not ready from acceptance until
// the result item has been taken.
// Reset: active_blocks returns to 64 and a clearing pass over all NUM_BLOCKS
// blocks marks every block free; req_chan stays not ready meanwhile.
// A stalled receiver holds the result in its output register and the
// block waits, taking no new item.
module contiguous_block_allocator #(
   parameter int NUM_BLOCKS = 64
) (
   input logic       clock,
   input logic       reset,
   cba_chan_if.sink   req_chan,
   cba_chan_if.source rsp_chan,
   cba_chan_if.sink   csr_chan
);
   localparam int IDX_W = $clog2(NUM_BLOCKS);

   logic [6:0]          active_ff;
   logic [6:0]          active_in;
   cba_pkg::map_wr_type map_wr;
   logic [IDX_W-1:0]    map_wr_addr;
   logic [IDX_W-1:0]    map_rd_addr;
   logic                map_rd_bit;
   cba_pkg::req_type    req_data;
   cba_pkg::rsp_type    rsp_data;

   assign csr_chan.ready = 1'b1;
   assign active_in      = csr_chan.valid ? csr_chan.data.active_blocks : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cba_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   assign req_data.command     = req_chan.data.command;
   assign req_data.run_length  = req_chan.data.run_length;
   assign req_data.first_block = req_chan.data.first_block;
   assign rsp_chan.data.status        = rsp_data.status;
   assign rsp_chan.data.granted_start = rsp_data.granted_start;

   cba_ctrl #(.NUM_BLOCKS(NUM_BLOCKS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_data     (rsp_data),
      .active_blocks(active_ff),
      .map_wr       (map_wr),
      .map_wr_addr  (map_wr_addr),
      .map_rd_addr  (map_rd_addr),
      .map_rd_bit   (map_rd_bit)
   );

   cba_bitmap #(.NUM_BLOCKS(NUM_BLOCKS)) u_bitmap (
      .clock  (clock),
      .wr     (map_wr),
      .wr_addr(map_wr_addr),
      .rd_addr(map_rd_addr),
      .rd_bit (map_rd_bit)
   );

`ifndef SYNTHESIS
   // a pending result blocks new commands
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("command accepted while result pending");

   // an accepted item is never followed by another in the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("back-to-back command acceptance");

   // only a successful allocate carries a start block
   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.data.status != cba_pkg::STATUS_DONE))
      |-> (rsp_chan.data.granted_start == 6'd0))
      else $error("start block reported on failed request");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.data.status == cba_pkg::STATUS_DONE ||
                          rsp_chan.data.status == cba_pkg::STATUS_NOSPACE ||
                          rsp_chan.data.status == cba_pkg::STATUS_INVALID))
      else $error("undefined status code");
`endif
endmodule

FILE: tb/tb_contiguous_block_allocator.sv
// Self-checking testbench for the first-fit contiguous block allocator.
`timescale 1ns / 1ps

module tb_contiguous_block_allocator;

   localparam int BLOCK_COUNT = 64;
   localparam int IDLE_PCT = 22;
   localparam int ITEMS_PER_PHASE = 75;

   typedef struct packed {
      logic [5:0] start;
      logic [6:0] len;
   } run_span_type;

   logic clock = 1'b0;
   logic reset;

   cba_chan_if #(.payload_type(cba_pkg::req_type)) req_chan ();
   cba_chan_if #(.payload_type(cba_pkg::rsp_type)) rsp_chan ();
   cba_chan_if #(.payload_type(cba_pkg::csr_type)) csr_chan ();

   contiguous_block_allocator #(.NUM_BLOCKS(BLOCK_COUNT)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // predictor state
   logic [BLOCK_COUNT-1:0] free_bits = '1;
   logic [6:0] block_limit = cba_pkg::ACTIVE_RESET;

   cba_pkg::rsp_type awaited_replies[$];
   run_span_type granted_runs[$];

   bit no_idle = 1'b0;
   int mismatches = 0;
   int items_sent = 0;
   int grants = 0;
   int no_space = 0;
   int rejects = 0;
   int limit_writes = 0;

   always #10 clock = ~clock;

   function automatic int usable_blocks();
      return (block_limit > BLOCK_COUNT) ? BLOCK_COUNT : int'(block_limit);
   endfunction

   // Applies one command to the predicted bitmap and returns the reply.
   function automatic cba_pkg::rsp_type first_fit_outcome(cba_pkg::req_type cmd_item);
      cba_pkg::rsp_type outcome;
      int limit;
      int idx;
      int run_start;
      int run_count;
      limit = usable_blocks();
      outcome.status = cba_pkg::STATUS_DONE;
      outcome.granted_start = '0;
      run_start = 0;
      run_count = 0;
      if (cmd_item.run_length == 0) begin
         outcome.status = cba_pkg::STATUS_INVALID;
      end else if (cmd_item.command == cba_pkg::CMD_ALLOC) begin
         if (int'(cmd_item.run_length) > limit) begin
            outcome.status = cba_pkg::STATUS_INVALID;
         end else begin
            for (idx = 0; idx < limit && run_count < int'(cmd_item.run_length); idx++) begin
               if (free_bits[idx]) begin
                  if (run_count == 0) run_start = idx;
                  run_count++;
               end else begin
                  run_count = 0;
               end
            end
            if (run_count == int'(cmd_item.run_length)) begin
               for (idx = run_start; idx < run_start + run_count; idx++)
                  free_bits[idx] = 1'b0;
               outcome.granted_start = run_start[5:0];
            end else begin
               outcome.status = cba_pkg::STATUS_NOSPACE;
            end
         end
      end else if (int'(cmd_item.first_block) + int'(cmd_item.run_length) > limit) begin
         outcome.status = cba_pkg::STATUS_INVALID;
      end else begin
         for (idx = cmd_item.first_block;
              idx < int'(cmd_item.first_block) + int'(cmd_item.run_length); idx++)
            free_bits[idx] = 1'b1;
      end
      return outcome;
   endfunction

   task automatic report_mismatch(string note);
      $display("MISMATCH at %0t ns: %s", $time, note);
      mismatches++;
   endtask

   // Sends one command item; the expected reply is queued at acceptance.
   task automatic send_command(logic cmd, logic [6:0] len, logic [5:0] first);
      cba_pkg::req_type item;
      cba_pkg::rsp_type want;
      item.command = cmd;
      item.run_length = len;
      item.first_block = first;
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) @(negedge clock);
      req_chan.data = item;
      req_chan.valid = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      want = first_fit_outcome(item);
      awaited_replies.push_back(want);
      items_sent++;
      case (want.status)
         cba_pkg::STATUS_DONE: begin
            if (cmd == cba_pkg::CMD_ALLOC) begin
               grants++;
               granted_runs.push_back('{start: want.granted_start, len: len});
            end
         end
         cba_pkg::STATUS_NOSPACE: no_space++;
         default: rejects++;
      endcase
   endtask

   task automatic alloc_run(logic [6:0] len);
      send_command(cba_pkg::CMD_ALLOC, len, 6'($urandom_range(63)));
   endtask

   task automatic free_run(logic [5:0] first, logic [6:0] len);
      send_command(cba_pkg::CMD_FREE, len, first);
   endtask

   // Drop valid and wait until every reply is back.
   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active_blocks(logic [6:0] value);
      settle();
      @(negedge clock);
      csr_chan.data.active_blocks = value;
      csr_chan.valid = 1'b1;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      block_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Zero length, full-disk allocate, no space, freeing past the end,
   // freeing free blocks, and first fit into a hole.
   task automatic test_directed_extremes();
      alloc_run(7'd0);
      free_run(6'd5, 7'd0);
      alloc_run(7'd64);
      alloc_run(7'd1);
      free_run(6'd63, 7'd1);
      free_run(6'd63, 7'd2);
      alloc_run(7'd1);
      free_run(6'd0, 7'd64);
      free_run(6'd0, 7'd64);
      alloc_run(7'd1);
      alloc_run(7'd3);
      alloc_run(7'd2);
      free_run(6'd1, 7'd3);
      alloc_run(7'd2);
      alloc_run(7'd4);
      free_run(6'd0, 7'd64);
      granted_runs.delete();
   endtask

   // Smallest, zero and oversized active block counts.
   task automatic test_active_count_limits();
      write_active_blocks(7'd1);
      alloc_run(7'd2);
      alloc_run(7'd1);
      free_run(6'd0, 7'd1);
      write_active_blocks(7'd0);
      alloc_run(7'd1);
      free_run(6'd0, 7'd1);
      write_active_blocks(7'd127);
      alloc_run(7'd64);
      free_run(6'd0, 7'd64);
      write_active_blocks(cba_pkg::ACTIVE_RESET);
      granted_runs.delete();
   endtask

   task automatic random_command();
      int pick;
      int lim;
      int idx;
      int len;
      run_span_type span;
      lim = usable_blocks();
      pick = $urandom_range(99);
      if (pick < 45) begin
         pick = $urandom_range(99);
         if (pick < 75) len = $urandom_range(1, (lim < 8) ? lim : 8);
         else if (pick < 93) len = $urandom_range(1, lim);
         else if (pick < 96) len = 0;
         else len = (lim < BLOCK_COUNT) ? lim + 1 : BLOCK_COUNT;
         alloc_run(7'(len));
      end else if (pick < 80 && granted_runs.size() != 0) begin
         // well-formed: release a run that was handed out earlier
         idx = $urandom_range(granted_runs.size() - 1);
         span = granted_runs[idx];
         granted_runs.delete(idx);
         free_run(span.start, span.len);
      end else if (pick < 96) begin
         len = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(0, 64);
         free_run(6'($urandom_range(63)), 7'(len));
      end else begin
         free_run(6'd0, 7'(lim));
         granted_runs.delete();
      end
   endtask

   // Random traffic over several active block counts; one phase runs with
   // both sides at full speed.
   task automatic test_random_traffic();
      int phase_limits[7];
      int ph;
      int k;
      phase_limits = '{64, 24, 1, 100, 0, 7, 64};
      phase_limits[4] = $urandom_range(2, 63);
      for (ph = 0; ph < 7; ph++) begin
         write_active_blocks(7'(phase_limits[ph]));
         no_idle = (ph == 1);
         for (k = 0; k < ITEMS_PER_PHASE; k++) random_command();
         settle();
         no_idle = 1'b0;
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_replies
      cba_pkg::rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("reply with none pending: status %0d start %0d",
                                      rsp_chan.data.status, rsp_chan.data.granted_start));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_chan.data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_chan.data.status, want.status));
            if (rsp_chan.data.granted_start !== want.granted_start)
               report_mismatch($sformatf("granted_start %0d, expected %0d",
                                         rsp_chan.data.granted_start, want.granted_start));
         end
      end
   end

   // result receiver back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_extremes();
      test_active_count_limits();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
      $display("Sent %0d commands: %0d runs granted, %0d without space, %0d rejected.",
               items_sent, grants, no_space, rejects);
      $display("Active block count written %0d times, from 0 up to 127.", limit_writes);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: contiguous_block_allocator.f
hw/rtl/cba_pkg.sv
hw/rtl/cba_chan_if.sv
hw/rtl/cba_bitmap.sv
hw/rtl/cba_ctrl.sv
hw/rtl/contiguous_block_allocator.sv
tb/tb_contiguous_block_allocator.sv
